[rtl/lifg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifg_pkg
// Types and constants shared by the leaky integrate-and-fire gate modules.
// ----------------------------------------------------------------------------
package lifg_pkg;

    localparam int THRESHOLD_LIMIT = 512;
    localparam int DELIVERY_LIMIT  = 512;
    localparam int MAX_INPUTS      = 4;
    localparam int LANE_COUNT      = 4;

    localparam int VALUE_W    = 16;
    localparam int CHARGE_W   = 24;
    localparam int DELIVERY_W = 11;
    localparam int THR_W      = 16;
    localparam int SUM_W      = VALUE_W + $clog2(LANE_COUNT);
    localparam int COUNT_W    = 3;

    localparam int DLV_POS_MAX = (DELIVERY_LIMIT < 1023) ? DELIVERY_LIMIT : 1023;
    localparam int DLV_NEG_MAX = (DELIVERY_LIMIT < 1024) ? DELIVERY_LIMIT : 1024;

    localparam logic signed [CHARGE_W-1:0] CHARGE_MAX = {1'b0, {(CHARGE_W-1){1'b1}}};
    localparam logic signed [CHARGE_W-1:0] CHARGE_MIN = {1'b1, {(CHARGE_W-1){1'b0}}};

    localparam logic [2:0] REG_DECAY         = 3'd0;
    localparam logic [2:0] REG_THRESHOLD     = 3'd1;
    localparam logic [2:0] REG_ACTIVATES     = 3'd2;
    localparam logic [2:0] REG_DELIVERY      = 3'd3;
    localparam logic [2:0] REG_DISCHARGE     = 3'd4;
    localparam logic [2:0] REG_THR_FROM_IN   = 3'd5;
    localparam logic [2:0] REG_DLV_FROM_IN   = 3'd6;
    localparam logic [2:0] REG_INPUT_COUNT   = 3'd7;

    localparam logic [1:0] DIS_CLEAR  = 2'd0;
    localparam logic [1:0] DIS_REDUCE = 2'd1;
    localparam logic [1:0] DIS_HALVE  = 2'd2;

    typedef struct packed {
        logic [8:0]                decay_amount;
        logic signed [10:0]        threshold_level;
        logic                      threshold_activates;
        logic signed [10:0]        delivery_level;
        logic [1:0]                discharge_mode;
        logic                      threshold_from_input;
        logic                      delivery_from_input;
        logic [COUNT_W-1:0]        input_count;
    } lifg_cfg_t;

    localparam lifg_cfg_t CFG_RESET = '{
        decay_amount:         9'd0,
        threshold_level:      11'sd0,
        threshold_activates:  1'b1,
        delivery_level:       11'sd256,
        discharge_mode:       DIS_CLEAR,
        threshold_from_input: 1'b0,
        delivery_from_input:  1'b0,
        input_count:          3'd1
    };

    typedef struct packed {
        logic signed [SUM_W-1:0]      in_sum;
        logic signed [THR_W-1:0]      threshold;
        logic signed [DELIVERY_W-1:0] delivery;
        logic [DELIVERY_W-1:0]        delivery_mag;
    } lifg_step_t;

    typedef struct packed {
        logic                         fired;
        logic signed [DELIVERY_W-1:0] delivered;
        logic signed [CHARGE_W-1:0]   charge;
    } lifg_result_t;

endpackage

[rtl/lifg_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifg_lane
// One input lane: passes its input value when the lane is within the active
// input count, zero otherwise.
// ----------------------------------------------------------------------------
module lifg_lane #(
    parameter int LANE_IDX = 0
) (
    input  logic signed [lifg_pkg::VALUE_W-1:0] value,
    input  logic [lifg_pkg::COUNT_W-1:0]        input_count,
    output logic signed [lifg_pkg::VALUE_W-1:0] lane_value
);
    import lifg_pkg::*;

    logic lane_on;

    assign lane_on    = (input_count > COUNT_W'(LANE_IDX)) && (LANE_IDX < MAX_INPUTS);
    assign lane_value = lane_on ? value : '0;

endmodule

[rtl/lifg_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifg_merge
// Merging stage: adds the lane values and registers the sum.
// ----------------------------------------------------------------------------
module lifg_merge (
    input  logic                                clk,
    input  logic                                load,
    input  logic signed [lifg_pkg::VALUE_W-1:0] lane_value [lifg_pkg::LANE_COUNT],
    output logic signed [lifg_pkg::SUM_W-1:0]   in_sum
);
    import lifg_pkg::*;

    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < LANE_COUNT; i++)
        begin
            sum_next = sum_next + SUM_W'(lane_value[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sum_reg <= sum_next;
        end
    end

    assign in_sum = sum_reg;

endmodule

[rtl/lifg_deliver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifg_deliver
// Delivery charge: selects the source, scales its magnitude by one minus the
// error fraction, clamps it and registers the signed charge and magnitude.
// ----------------------------------------------------------------------------
module lifg_deliver (
    input  logic                                   clk,
    input  logic                                   load,
    input  logic                                   from_input,
    input  logic signed [10:0]                     delivery_level,
    input  logic signed [lifg_pkg::VALUE_W-1:0]    node_value,
    input  logic [15:0]                            error_draw,
    output logic signed [lifg_pkg::DELIVERY_W-1:0] delivery,
    output logic [lifg_pkg::DELIVERY_W-1:0]        delivery_mag
);
    import lifg_pkg::*;

    logic signed [VALUE_W-1:0]    src;
    logic                         neg;
    logic [VALUE_W-1:0]           src_mag;
    logic [16:0]                  factor;
    logic [VALUE_W+16:0]          product;
    logic [16:0]                  mag;
    logic [DELIVERY_W-1:0]        lim;
    logic [DELIVERY_W-1:0]        mag_c;
    logic signed [DELIVERY_W-1:0] dlv_reg;
    logic signed [DELIVERY_W-1:0] dlv_next;
    logic [DELIVERY_W-1:0]        mag_reg;

    always_comb
    begin
        src     = from_input ? node_value : VALUE_W'(delivery_level);
        neg     = src[VALUE_W-1];
        src_mag = neg ? VALUE_W'(-src) : VALUE_W'(src);
        factor  = 17'h10000 - {1'b0, error_draw};
        product = (VALUE_W+17)'(src_mag) * (VALUE_W+17)'(factor);
        mag     = product[VALUE_W+16 -: 17];
        lim     = neg ? DELIVERY_W'(DLV_NEG_MAX) : DELIVERY_W'(DLV_POS_MAX);
        mag_c   = (mag > 17'(lim)) ? lim : DELIVERY_W'(mag);
        dlv_next = neg ? -$signed(mag_c) : $signed(mag_c);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dlv_reg <= dlv_next;
            mag_reg <= mag_c;
        end
    end

    assign delivery     = dlv_reg;
    assign delivery_mag = mag_reg;

endmodule

[rtl/lifg_charge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifg_charge
// Membrane charge loop: decay, input sum, saturation, threshold compare and
// discharge, with the stored charge register.
// ----------------------------------------------------------------------------
module lifg_charge (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   update,
    input  lifg_pkg::lifg_cfg_t    cfg,
    input  lifg_pkg::lifg_step_t   step,
    output lifg_pkg::lifg_result_t result
);
    import lifg_pkg::*;

    logic signed [CHARGE_W-1:0] charge_reg;
    logic signed [CHARGE_W-1:0] charge_next;
    logic signed [CHARGE_W:0]   decay_ext;
    logic signed [CHARGE_W:0]   mag_ext;
    logic signed [CHARGE_W:0]   decayed;
    logic signed [CHARGE_W+1:0] summed;
    logic signed [CHARGE_W-1:0] c_sat;
    logic signed [CHARGE_W:0]   reduced;
    logic signed [CHARGE_W:0]   halved;
    logic                       fire;

    always_comb
    begin
        decay_ext = $signed({{(CHARGE_W+1-9){1'b0}}, cfg.decay_amount});
        mag_ext   = $signed({{(CHARGE_W+1-DELIVERY_W){1'b0}}, step.delivery_mag});

        if (charge_reg > 0)
            decayed = (CHARGE_W+1)'(charge_reg) - decay_ext;
        else if (charge_reg < 0)
            decayed = (CHARGE_W+1)'(charge_reg) + decay_ext;
        else
            decayed = '0;

        summed = (CHARGE_W+2)'(decayed) + (CHARGE_W+2)'(step.in_sum);

        if (summed > (CHARGE_W+2)'(CHARGE_MAX))
            c_sat = CHARGE_MAX;
        else if (summed < (CHARGE_W+2)'(CHARGE_MIN))
            c_sat = CHARGE_MIN;
        else
            c_sat = CHARGE_W'(summed);

        if (cfg.threshold_activates)
            fire = c_sat > CHARGE_W'(step.threshold);
        else
            fire = c_sat < CHARGE_W'(step.threshold);

        // magnitude minus delivery magnitude, sign kept, may cross zero
        if (c_sat > 0)
            reduced = (CHARGE_W+1)'(c_sat) - mag_ext;
        else if (c_sat < 0)
            reduced = (CHARGE_W+1)'(c_sat) + mag_ext;
        else
            reduced = '0;

        // halve toward zero
        if (c_sat < 0)
            halved = ((CHARGE_W+1)'(c_sat) + (CHARGE_W+1)'(1)) >>> 1;
        else
            halved = (CHARGE_W+1)'(c_sat) >>> 1;

        charge_next = c_sat;
        if (fire)
        begin
            case (cfg.discharge_mode)
                DIS_CLEAR:  charge_next = '0;
                DIS_REDUCE: charge_next = CHARGE_W'(reduced);
                DIS_HALVE:  charge_next = CHARGE_W'(halved);
                default:    charge_next = c_sat;
            endcase
        end

        result.fired     = fire;
        result.delivered = fire ? step.delivery : '0;
        result.charge    = charge_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            charge_reg <= '0;
        else if (update)
            charge_reg <= charge_next;
    end

endmodule

[rtl/leaky_integrate_fire_gate_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leaky_integrate_fire_gate_top
// Leaky integrate-and-fire gate: four input lanes, delivery scaling and a
// membrane charge update with an output register.
//
// channel  | direction | word
// s_*      | in        | seven 16-bit fields, one neuron step
// m_*      | out       | delivered charge and new charge; tuser = fired
// cfg_*    | in        | register index and write data
//
// one word accepted and one delivered per cycle when m_tready stays high
// registered stages in order: lane merge and delivery scaling, then the charge loop
// the charge loop (decay, add, compare, discharge) closes combinationally on the charge register
// reset clears the charge to zero and loads the register reset values
// m_tready low holds the output word; one more word waits in the first stage
// ----------------------------------------------------------------------------
module leaky_integrate_fire_gate_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,   // in_value_0..3, threshold_node_value,
                                    // delivery_node_value, error_draw
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,   // delivered_charge, charge_now, zero pad
    output logic [0:0]   m_tuser,   // fired
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [10:0]  cfg_data
);
    import lifg_pkg::*;

    lifg_cfg_t               cfg_reg;
    lifg_cfg_t               cfg_next;
    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic signed [THR_W-1:0] thr_reg;
    logic signed [THR_W-1:0] thr_next;
    logic signed [THR_W-1:0] thr_src;
    lifg_result_t            result_reg;
    lifg_result_t            result_next;
    lifg_step_t              step;
    logic                    advance;
    logic                    load;

    logic signed [VALUE_W-1:0] lane_in  [LANE_COUNT];
    logic signed [VALUE_W-1:0] lane_out [LANE_COUNT];

    // config
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DECAY:       cfg_next.decay_amount         = cfg_data[8:0];
                REG_THRESHOLD:   cfg_next.threshold_level      = cfg_data;
                REG_ACTIVATES:   cfg_next.threshold_activates  = cfg_data[0];
                REG_DELIVERY:    cfg_next.delivery_level       = cfg_data;
                REG_DISCHARGE:   cfg_next.discharge_mode       = cfg_data[1:0];
                REG_THR_FROM_IN: cfg_next.threshold_from_input = cfg_data[0];
                REG_DLV_FROM_IN: cfg_next.delivery_from_input  = cfg_data[0];
                REG_INPUT_COUNT: cfg_next.input_count          = cfg_data[2:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    // pipeline control
    assign advance   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !s1_valid_reg || advance;
    assign load      = s_tvalid && s_tready;

    always_comb
    begin
        if (load)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input lanes and merge
    for (genvar i = 0; i < LANE_COUNT; i++)
    begin : g_lane
        assign lane_in[i] = s_tdata[i*VALUE_W +: VALUE_W];

        lifg_lane #(
            .LANE_IDX (i)
        ) u_lane (
            .value       (lane_in[i]),
            .input_count (cfg_reg.input_count),
            .lane_value  (lane_out[i])
        );
    end

    lifg_merge u_merge (
        .clk        (clk),
        .load       (load),
        .lane_value (lane_out),
        .in_sum     (step.in_sum)
    );

    // threshold select and clamp
    always_comb
    begin
        thr_src = cfg_reg.threshold_from_input ? s_tdata[4*VALUE_W +: VALUE_W]
                                               : THR_W'(cfg_reg.threshold_level);
        if (thr_src > THR_W'(THRESHOLD_LIMIT))
            thr_next = THR_W'(THRESHOLD_LIMIT);
        else if (thr_src < -THR_W'(THRESHOLD_LIMIT))
            thr_next = -THR_W'(THRESHOLD_LIMIT);
        else
            thr_next = thr_src;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            thr_reg <= thr_next;
    end

    assign step.threshold = thr_reg;

    lifg_deliver u_deliver (
        .clk            (clk),
        .load           (load),
        .from_input     (cfg_reg.delivery_from_input),
        .delivery_level (cfg_reg.delivery_level),
        .node_value     (s_tdata[5*VALUE_W +: VALUE_W]),
        .error_draw     (s_tdata[6*VALUE_W +: 16]),
        .delivery       (step.delivery),
        .delivery_mag   (step.delivery_mag)
    );

    lifg_charge u_charge (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (advance),
        .cfg    (cfg_reg),
        .step   (step),
        .result (result_next)
    );

    // output word
    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, result_reg.charge, result_reg.delivered};
    assign m_tuser  = result_reg.fired;

endmodule

[rtl/lifg_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifg_checker
// Port-level checks for the leaky integrate-and-fire gate, bound to the top.
// ----------------------------------------------------------------------------
module lifg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [0:0]  m_tuser
);
    import lifg_pkg::*;

    // stalled output word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // no delivery without a fire
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[DELIVERY_W-1:0] == '0)
        else $error("delivered charge without fire");

    // delivered charge stays within the delivery limit
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[DELIVERY_W-1:0]) <= DLV_POS_MAX) &&
                     ($signed(m_tdata[DELIVERY_W-1:0]) >= -DLV_NEG_MAX))
        else $error("delivered charge out of range");

    // input side stalls only behind a full output stage
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with free output stage");

endmodule

bind leaky_integrate_fire_gate_top lifg_checker u_lifg_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
